>>> hdl/pps_pkg.sv
// Shared constants and types for the preemptive priority scheduler.
// No dependencies; imported by every module in this block.
package pps_pkg;

	localparam int SLOTS     = 8;
	localparam int TIME_BITS = 16;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);

	// fixed field widths
	localparam int CFG_W   = 4;
	localparam int SLOT_FW = 3;
	localparam int BURST_W = 8;
	localparam int ARR_W   = 16;
	localparam int RANK_W  = 8;
	localparam int TIME_FW = 16;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic load;    // write one slot from the input item
		logic start;   // tick accepted: clear scan state
		logic scan;    // examine the slot at the scan index
		logic finish;  // apply the tick and fill the result register
	} pps_cmd_t;

	typedef struct packed {
		logic scan_last;  // scan index is on the last slot in use
		logic n_zero;     // no slots in use
	} pps_stat_t;

endpackage

>>> hdl/pps_ctrl.sv
// Sequencer for the scheduler: idle, slot scan, finish.
// Depends on pps_pkg; drives pps_dp through pps_cmd_t.
module pps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  logic              out_stall,
	input  pps_pkg::pps_stat_t stat,
	output pps_pkg::pps_cmd_t  cmd,
	output logic              in_stall,
	output logic              out_valid
);
	import pps_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_take;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load   = in_take && (opcode == OP_LOAD);
		cmd.start  = in_take && (opcode == OP_TICK);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= stat.n_zero ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/pps_dp.sv
// Datapath: task slot table, time counter, scan selector, result register.
// Depends on pps_pkg; commanded by pps_ctrl.
module pps_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pps_pkg::pps_cmd_t            cmd,
	output pps_pkg::pps_stat_t           stat,
	input  logic                         cfg_we,
	input  logic [pps_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic [pps_pkg::SLOT_FW-1:0]  slot,
	input  logic [pps_pkg::BURST_W-1:0]  burst,
	input  logic [pps_pkg::ARR_W-1:0]    arrival,
	input  logic [pps_pkg::RANK_W-1:0]   urgency,
	output logic [pps_pkg::SLOT_FW-1:0]  served_slot,
	output logic                         idle,
	output logic                         finished,
	output logic [pps_pkg::TIME_FW-1:0]  now,
	output logic [pps_pkg::TIME_FW-1:0]  turnaround,
	output logic [pps_pkg::TIME_FW-1:0]  waiting,
	output logic                         all_done
);
	import pps_pkg::*;

	logic [CFG_W-1:0]     task_count_q;
	logic [TIME_BITS-1:0] clock_q;
	logic [BURST_W-1:0]   rem_q  [SLOTS];
	logic [BURST_W-1:0]   full_q [SLOTS];
	logic [ARR_W-1:0]     arr_q  [SLOTS];
	logic [RANK_W-1:0]    rank_q [SLOTS];

	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     nz_q;      // in-use slots with service owed
	logic                 found_q;
	logic [SLOT_W-1:0]    best_q;
	logic [RANK_W-1:0]    best_rank_q;
	logic [ARR_W-1:0]     best_arr_q;
	logic [BURST_W-1:0]   best_full_q;
	logic [BURST_W-1:0]   best_rem_q;

	logic [SLOT_FW-1:0]   o_slot_q;
	logic                 o_idle_q;
	logic                 o_fin_q;
	logic [TIME_FW-1:0]   o_now_q;
	logic [TIME_FW-1:0]   o_turn_q;
	logic [TIME_FW-1:0]   o_wait_q;
	logic                 o_done_q;

	logic [CNT_W-1:0]     n_use;
	logic [SLOT_W-1:0]    scan_i;
	logic [SLOT_W-1:0]    load_i;
	logic                 scan_nz;
	logic                 scan_take;
	logic                 all_fin;
	logic                 served;
	logic                 fin_now;
	logic [TIME_BITS-1:0] clock_next;
	logic [TIME_BITS-1:0] turn;
	logic [TIME_BITS-1:0] full_ext;
	logic [TIME_BITS-1:0] wait_v;

	// task_count above SLOTS acts as SLOTS
	assign n_use  = (32'(task_count_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(task_count_q);
	assign scan_i = idx_q[SLOT_W-1:0];
	assign load_i = SLOT_W'(slot);

	assign stat.scan_last = (idx_q == n_use - CNT_W'(1));
	assign stat.n_zero    = (n_use == '0);

	assign scan_nz   = (rem_q[scan_i] != '0);
	assign scan_take = scan_nz && (TIME_BITS'(arr_q[scan_i]) <= clock_q)
	                   && (!found_q || (rank_q[scan_i] < best_rank_q));

	assign all_fin    = (nz_q == '0);
	assign served     = found_q && !all_fin;
	assign fin_now    = served && (best_rem_q == BURST_W'(1));
	assign clock_next = (clock_q == TIME_MAX) ? clock_q : clock_q + TIME_BITS'(1);
	assign turn       = clock_next - TIME_BITS'(best_arr_q);
	assign full_ext   = TIME_BITS'(best_full_q);
	assign wait_v     = (turn >= full_ext) ? turn - full_ext : '0;

	// control state and the owed-service table clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			clock_q      <= '0;
			idx_q        <= '0;
			nz_q         <= '0;
			found_q      <= 1'b0;
			for (int k = 0; k < SLOTS; k++) begin
				rem_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
			if (cmd.load && (32'(slot) < SLOTS)) begin
				rem_q[load_i] <= burst;
			end
			if (cmd.start) begin
				idx_q   <= '0;
				nz_q    <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + CNT_W'(1);
				if (scan_nz) begin
					nz_q <= nz_q + CNT_W'(1);
				end
				if (scan_take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.finish && !all_fin) begin
				clock_q <= clock_next;
				if (served) begin
					rem_q[best_q] <= best_rem_q - BURST_W'(1);
				end
			end
		end
	end

	// payload: slot fields, running best, result register
	always_ff @(posedge clk) begin
		if (cmd.load && (32'(slot) < SLOTS)) begin
			full_q[load_i] <= burst;
			arr_q[load_i]  <= arrival;
			rank_q[load_i] <= urgency;
		end
		if (cmd.scan && scan_take) begin
			best_q      <= scan_i;
			best_rank_q <= rank_q[scan_i];
			best_arr_q  <= arr_q[scan_i];
			best_full_q <= full_q[scan_i];
			best_rem_q  <= rem_q[scan_i];
		end
		if (cmd.finish) begin
			o_slot_q <= served ? SLOT_FW'(best_q) : '0;
			o_idle_q <= !served;
			o_fin_q  <= fin_now;
			o_now_q  <= all_fin ? TIME_FW'(clock_q) : TIME_FW'(clock_next);
			o_turn_q <= fin_now ? TIME_FW'(turn) : '0;
			o_wait_q <= fin_now ? TIME_FW'(wait_v) : '0;
			o_done_q <= all_fin || ((nz_q == CNT_W'(1)) && fin_now);
		end
	end

	assign served_slot = o_slot_q;
	assign idle        = o_idle_q;
	assign finished    = o_fin_q;
	assign now         = o_now_q;
	assign turnaround  = o_turn_q;
	assign waiting     = o_wait_q;
	assign all_done    = o_done_q;

endmodule

>>> hdl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: pps_ctrl sequencer plus pps_dp datapath.
// Depends on pps_pkg, pps_ctrl and pps_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  cfg     | cfg_we                 | cfg_wdata = task_count
//  in      | in_valid / in_stall    | opcode, slot, burst, arrival, urgency
//  out     | out_valid / out_stall  | served_slot, idle, finished, now, turnaround,
//          |                        | waiting, all_done
//
// A load item writes its slot at the edge where it is taken; it gives no item out.
// For a tick item, n = slots in use (0..8): the slot table is scanned one slot per cycle over
// the n slots for the most urgent ready task, then the finish state applies the tick.
// The finish cycle waits while the result register is still held by out_stall; the next
// item is accepted as soon as the tick has been written to the result register.
// arst_n clears the time counter, task_count, owed service and the handshake state;
// burst, arrival and rank of a slot are undefined until it is loaded.
module preemptive_priority_scheduler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pps_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [pps_pkg::SLOT_FW-1:0]  slot,
	input  logic [pps_pkg::BURST_W-1:0]  burst,
	input  logic [pps_pkg::ARR_W-1:0]    arrival,
	input  logic [pps_pkg::RANK_W-1:0]   urgency,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pps_pkg::SLOT_FW-1:0]  served_slot,
	output logic                         idle,
	output logic                         finished,
	output logic [pps_pkg::TIME_FW-1:0]  now,
	output logic [pps_pkg::TIME_FW-1:0]  turnaround,
	output logic [pps_pkg::TIME_FW-1:0]  waiting,
	output logic                         all_done
);
	import pps_pkg::*;

	pps_cmd_t  cmd;
	pps_stat_t stat;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	pps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.slot        (slot),
		.burst       (burst),
		.arrival     (arrival),
		.urgency     (urgency),
		.served_slot (served_slot),
		.idle        (idle),
		.finished    (finished),
		.now         (now),
		.turnaround  (turnaround),
		.waiting     (waiting),
		.all_done    (all_done)
	);

	// an accepted tick moves the sequencer out of idle, which raises in_stall
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_TICK) |=> in_stall)
		else $error("tick accepted without entering scan/finish");

	// an idle tick names no slot and completes nothing
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> (served_slot == '0) && !finished)
		else $error("idle result carries slot or completion");

	// waiting never exceeds turnaround
	a_wait_le_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> (waiting <= turnaround))
		else $error("waiting larger than turnaround");

	// an all-done report without service leaves time where it was
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && all_done |=> !out_valid || !idle || !all_done
		|| $stable(now))
		else $error("time advanced after all tasks finished");

endmodule

>>> tb/tb_preemptive_priority_scheduler.sv
// Self-checking testbench for preemptive_priority_scheduler: a scoreboard class predicts
// every tick item, plain tasks drive loads, ticks and task_count writes.
// Depends on pps_pkg and the preemptive_priority_scheduler RTL.
module tb_preemptive_priority_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import pps_pkg::*;

	// Stop criteria. About 1600 items, plus idle bursts on both sides, the settle gaps
	// and the one long hold-off, make up the run; the cycle limit is set above what
	// that run needs, so that only a hang reaches it.
	localparam int RANDOM_ITEMS = 1350;
	localparam int TOTAL_ITEMS  = 1600;
	localparam int CYCLE_LIMIT  = 250_000;
	localparam int SCENARIO_CAP = 300;   // items before a scenario gives up on owed service
	localparam int SETTLE_CYC   = 12;    // idle gap after the last result, before a register write
	localparam int LONG_HOLD    = 300;   // one long out_stall, to back the block up

	// One result item, in the order of the output ports.
	typedef struct packed {
		logic [SLOT_FW-1:0] served;
		logic               idle;
		logic               finished;
		logic [TIME_FW-1:0] at_time;
		logic [TIME_FW-1:0] turnaround;
		logic [TIME_FW-1:0] waiting;
		logic               all_done;
	} sched_result_t;

	// Scoreboard: keeps its own copy of the slot table, the time counter and task_count.
	// note_item() runs the schedule for each accepted item and queues what a tick must
	// report; check_result() pops the oldest entry and compares it field by field.
	class sched_scoreboard;
		logic [BURST_W-1:0] owed     [SLOTS];
		logic [BURST_W-1:0] full_len [SLOTS];
		logic [ARR_W-1:0]   ready_at [SLOTS];
		logic [RANK_W-1:0]  prio     [SLOTS];
		logic [TIME_FW-1:0] sim_now;
		int                 in_use;
		sched_result_t      due[$];
		int                 errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				owed[i]     = '0;
				full_len[i] = '0;
				ready_at[i] = '0;
				prio[i]     = '0;
			end
			sim_now = '0;
			in_use  = 0;
			errors  = 0;
		endfunction

		// counts above the table size act as a full table
		function void set_task_count(logic [CFG_W-1:0] v);
			in_use = (v > SLOTS) ? SLOTS : int'(v);
		endfunction

		function bit nothing_owed();
			for (int i = 0; i < in_use; i++)
				if (owed[i] != '0)
					return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_item(logic op, logic [SLOT_FW-1:0] sl, logic [BURST_W-1:0] bu,
				logic [ARR_W-1:0] ar, logic [RANK_W-1:0] ur);
			sched_result_t r;
			int            best;
			bit            found;
			logic [15:0]   turn;
			if (op == OP_LOAD) begin
				owed[sl]     = bu;
				full_len[sl] = bu;
				ready_at[sl] = ar;
				prio[sl]     = ur;
				return;
			end
			r = '0;
			// every slot in use is done: report it and leave time alone
			if (nothing_owed()) begin
				r.idle     = 1'b1;
				r.at_time  = sim_now;
				r.all_done = 1'b1;
				due.push_back(r);
				return;
			end
			// most urgent ready slot; strict compare keeps the lowest index on a tie
			best  = 0;
			found = 1'b0;
			for (int i = 0; i < in_use; i++) begin
				if (owed[i] != '0 && ready_at[i] <= sim_now) begin
					if (!found || prio[i] < prio[best]) begin
						best  = i;
						found = 1'b1;
					end
				end
			end
			// time saturates at its top value
			if (sim_now != '1)
				sim_now = sim_now + 16'd1;
			r.at_time = sim_now;
			r.idle    = !found;
			if (found) begin
				r.served   = 3'(best);
				owed[best] = owed[best] - 8'd1;
				if (owed[best] == '0) begin
					turn         = sim_now - ready_at[best];
					r.finished   = 1'b1;
					r.turnaround = turn;
					// a task that ran into saturated time may show less than its burst
					r.waiting    = (turn >= {8'd0, full_len[best]})
						? turn - {8'd0, full_len[best]} : 16'd0;
				end
			end
			r.all_done = nothing_owed();
			due.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t MISMATCH %s", $time, msg);
			errors++;
		endtask

		task cmp(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_result(sched_result_t got);
			sched_result_t want;
			if (due.size() == 0) begin
				report($sformatf("result item with nothing pending (slot %0d, now %0d)",
					got.served, got.at_time));
				return;
			end
			want = due.pop_front();
			cmp("served_slot", 16'(got.served), 16'(want.served));
			cmp("idle", 16'(got.idle), 16'(want.idle));
			cmp("finished", 16'(got.finished), 16'(want.finished));
			cmp("now", got.at_time, want.at_time);
			cmp("turnaround", got.turnaround, want.turnaround);
			cmp("waiting", got.waiting, want.waiting);
			cmp("all_done", 16'(got.all_done), 16'(want.all_done));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic [SLOT_FW-1:0] slot;
	logic [BURST_W-1:0] burst;
	logic [ARR_W-1:0]   arrival;
	logic [RANK_W-1:0]  urgency;
	logic               out_valid;
	logic               out_stall;
	logic [SLOT_FW-1:0] served_slot;
	logic               idle;
	logic               finished;
	logic [TIME_FW-1:0] now;
	logic [TIME_FW-1:0] turnaround;
	logic [TIME_FW-1:0] waiting;
	logic               all_done;

	sched_scoreboard sb = new();

	int items_sent = 0;
	int cycles     = 0;
	bit quiet_tx   = 1'b0;  // sender runs without gaps for this scenario
	bit no_idle    = 1'b0;  // last phase: neither side idles
	bit hold_on    = 1'b0;  // sender asks the receiver for its one long hold-off
	bit hold_done  = 1'b0;

	preemptive_priority_scheduler i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.slot        (slot),
		.burst       (burst),
		.arrival     (arrival),
		.urgency     (urgency),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.served_slot (served_slot),
		.idle        (idle),
		.finished    (finished),
		.now         (now),
		.turnaround  (turnaround),
		.waiting     (waiting),
		.all_done    (all_done)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Arrival a few ticks either side of the predicted time counter, so most tasks
	// become ready soon and the schedule actually runs.
	function automatic logic [15:0] near_now();
		int t;
		t = int'(sb.sim_now) + int'($urandom_range(0, 6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return 16'(t);
	endfunction

	// Mostly short bursts; now and then zero or anything up to the field maximum.
	function automatic logic [7:0] pick_burst();
		case ($urandom_range(0, 19))
			0: return 8'd0;
			1: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(1, 6));
		endcase
	endfunction

	// Half the time a narrow range, so that equal ranks and the tie rule come up often.
	function automatic logic [7:0] pick_urgency();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one item and hold it until the block takes it. Valid is only lowered for a
	// gap; a back-to-back item keeps valid high and only swaps the payload.
	task automatic send_item(logic op, logic [SLOT_FW-1:0] sl, logic [BURST_W-1:0] bu,
			logic [ARR_W-1:0] ar, logic [RANK_W-1:0] ur);
		int gap;
		if (!no_idle && !quiet_tx && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		slot     <= sl;
		burst    <= bu;
		arrival  <= ar;
		urgency  <= ur;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(op, sl, bu, ar, ur);
		items_sent++;
	endtask

	// A tick ignores its payload; random bits there still toggle every field.
	task automatic tick();
		send_item(OP_TICK, 3'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Drop valid, let every expected result come back, then give the block time to finish
	// a trailing load before touching the register.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_count(logic [CFG_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_task_count(v);
	endtask

	// Hand-picked sequence: empty table, a slot outside the count, a count above the
	// table size, idle tick, equal ranks, preemption by a late urgent task, zero burst,
	// field extremes, and ticks after everything is done.
	task automatic directed_checks();
		write_count(4'd0);
		tick();
		send_item(OP_LOAD, 3'd7, 8'd255, 16'hFFFF, 8'd255);
		tick();
		write_count(4'd15);
		tick();
		send_item(OP_LOAD, 3'd0, 8'd4, 16'd0, 8'd5);
		send_item(OP_LOAD, 3'd1, 8'd1, 16'd0, 8'd5);
		send_item(OP_LOAD, 3'd2, 8'd1, 16'd3, 8'd0);
		send_item(OP_LOAD, 3'd3, 8'd0, 16'd0, 8'd0);
		repeat (6) tick();
		send_item(OP_LOAD, 3'd7, 8'd0, 16'd0, 8'd0);
		repeat (2) tick();
	endtask

	// One random scenario: pick a count, fill every slot in use, then tick until all
	// owed service is gone, with the odd reload in mid run. Slots above the count get
	// stray loads now and then. The pressure scenario uses a full table with long bursts
	// and asks the receiver for its long hold-off.
	task automatic run_scenario(bit pressure);
		logic [CFG_W-1:0] cnt;
		int               n;
		int               i;
		int               ticks;
		case ($urandom_range(0, 9))
			0: cnt = 4'd0;
			1: cnt = 4'($urandom_range(9, 15));
			2: cnt = 4'd8;
			default: cnt = 4'($urandom_range(1, 8));
		endcase
		if (pressure)
			cnt = 4'd8;
		write_count(cnt);
		quiet_tx = ($urandom_range(0, 3) == 0);
		n = sb.in_use;
		for (i = 0; i < n; i++)
			send_item(OP_LOAD, 3'(i), pressure ? 8'($urandom_range(10, 20)) : pick_burst(),
				near_now(), pick_urgency());
		if (n < SLOTS && $urandom_range(0, 2) == 0)
			send_item(OP_LOAD, 3'($urandom_range(n, SLOTS - 1)), 8'($urandom),
				16'($urandom), 8'($urandom));
		if (pressure)
			hold_on = 1'b1;
		ticks = 0;
		while (!sb.nothing_owed() && ticks < SCENARIO_CAP) begin
			if (n > 0 && $urandom_range(0, 19) == 0)
				send_item(OP_LOAD, 3'($urandom_range(0, n - 1)), pick_burst(), near_now(),
					pick_urgency());
			else
				tick();
			ticks++;
		end
		repeat ($urandom_range(1, 2)) tick();
	endtask

	// Last phase, no idling: a full table and one unbroken stream of ticks and reloads,
	// with no register write in between, up to the item budget.
	task automatic final_stream();
		write_count(4'd8);
		no_idle = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			if (sb.nothing_owed() || $urandom_range(0, 9) == 0)
				send_item(OP_LOAD, 3'($urandom_range(0, SLOTS - 1)), pick_burst(),
					near_now(), pick_urgency());
			else
				tick();
		end
		repeat (2) tick();
	endtask

	// Result side: check each accepted item, then decide the next cycle's out_stall.
	// Random stall bursts, quiet windows in which no new stall burst starts, and one
	// long hold-off on request from the sender.
	initial begin : result_side
		sched_result_t got;
		int            stall_left;
		int            hold_left;
		int            window;
		bit            quiet_rx;
		stall_left = 0;
		hold_left  = 0;
		window     = 0;
		quiet_rx   = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.served     = served_slot;
				got.idle       = idle;
				got.finished   = finished;
				got.at_time    = now;
				got.turnaround = turnaround;
				got.waiting    = waiting;
				got.all_done   = all_done;
				sb.check_result(got);
			end
			window++;
			if (window == 128) begin
				window   = 0;
				quiet_rx = ($urandom_range(0, 3) == 0);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_on && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!no_idle && !quiet_rx && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sender side and overall sequence.
	initial begin : item_side
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_LOAD;
		slot      <= '0;
		burst     <= '0;
		arrival   <= '0;
		urgency   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		run_scenario(1'b1);
		while (items_sent < RANDOM_ITEMS)
			run_scenario(1'b0);
		final_stream();
		settle();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
